FILE: rtl/sorted_priority_queue_core_defines.svh
// Assertion macros for the sorted priority queue core.
`ifndef SORTED_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_CORE_DEFINES_SVH

`ifndef SYNTHESIS

`define SPQ_ASSERT(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("spq assertion failed");

`define SPQ_ASSERT_RST(label, expr) \
  label: assert property (@(posedge clk) (expr)) \
    else $error("spq reset assertion failed");

`else

`define SPQ_ASSERT(label, expr)

`define SPQ_ASSERT_RST(label, expr)

`endif

`endif

FILE: rtl/spq_pkg.sv
package spq_pkg;

  localparam int DATA_W = 32;
  localparam int PRIO_W = 16;
  localparam int FILL_W = 5;

  localparam logic [1:0] REQ_ENQ  = 2'd0;
  localparam logic [1:0] REQ_DEQ  = 2'd1;
  localparam logic [1:0] REQ_PEEK = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic [PRIO_W-1:0]        prio;
  } entry_t;

  typedef struct packed {
    logic   enq;
    logic   deq;
    entry_t item;
  } cell_ctrl_t;

endpackage

FILE: rtl/spq_cell.sv
module spq_cell import spq_pkg::*; (
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic       valid,
  input  logic       left_keep,
  input  entry_t     left_entry,
  input  entry_t     right_entry,
  output entry_t     entry,
  output logic       keep
);

  // stay in place when this entry sorts at or before the new one
  assign keep = valid && (entry.prio <= ctrl.item.prio);

  always_ff @(posedge clk) begin
    if (ctrl.enq) begin
      if (!keep) begin
        entry <= left_keep ? ctrl.item : left_entry;
      end
    end else if (ctrl.deq) begin
      entry <= right_entry;
    end
  end

endmodule

FILE: rtl/sorted_priority_queue_core.sv
// Channel | Dir | tdata (low bit up)                         | tuser
// s_*     | in  | item_data[31:0] item_priority[47:32]        | req_type[1:0]
// m_*     | out | head_data[31:0] fill_count[36:32]           | status[1:0]
//         |     | is_empty[37], zero fill to bit 39            |
// One request per cycle: the cell row compares every slot against the new
// priority and shifts in the same edge, the result lands in the output register.
// The next request is taken while the output register is empty or drained.
// A stalled m_tready holds the result and stops intake; no other stalls.
// Synchronous reset empties the queue; slot contents are kept.
`include "sorted_priority_queue_core_defines.svh"

module sorted_priority_queue_core import spq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // item_data, item_priority
  input  logic [1:0]  s_tuser,   // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // head_data, fill_count, is_empty
  output logic [1:0]  m_tuser    // status
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0] count, count_next;
  logic          s_accept;
  cell_ctrl_t    ctrl;
  entry_t        cell_q [DEPTH];
  logic          keep [DEPTH];

  logic                     out_valid;
  logic signed [DATA_W-1:0] out_head, res_head;
  logic [1:0]               out_status, res_status;
  logic [FILL_W-1:0]        out_fill;
  logic                     out_empty;
  logic [CW+FILL_W-1:0]     fill_ext;

  assign s_tready = !out_valid || m_tready;
  assign s_accept = s_tvalid && s_tready;

  always_comb begin
    ctrl.enq       = 1'b0;
    ctrl.deq       = 1'b0;
    ctrl.item.data = s_tdata[DATA_W-1:0];
    ctrl.item.prio = s_tdata[DATA_W+PRIO_W-1:DATA_W];
    res_head       = '0;
    res_status     = ST_OK;
    count_next     = count;
    unique case (s_tuser)
      REQ_ENQ: begin
        if (count == CW'(DEPTH)) begin
          res_status = ST_FULL;
        end else begin
          ctrl.enq   = s_accept;
          count_next = count + 1'b1;
        end
      end
      REQ_DEQ: begin
        if (count == '0) begin
          res_status = ST_EMPTY;
        end else begin
          ctrl.deq   = s_accept;
          res_head   = cell_q[0].data;
          count_next = count - 1'b1;
        end
      end
      REQ_PEEK: begin
        if (count == '0) begin
          res_status = ST_EMPTY;
        end else begin
          res_head = cell_q[0].data;
        end
      end
      default: begin
      end
    endcase
  end

  assign fill_ext = {{FILL_W{1'b0}}, count_next};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic   valid, left_keep;
    entry_t left_entry, right_entry;

    assign valid = CW'(i) < count;
    if (i == 0) begin : g_head
      assign left_keep  = 1'b1;
      assign left_entry = ctrl.item;
    end else begin : g_body
      assign left_keep  = keep[i-1];
      assign left_entry = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_entry = cell_q[i];
    end else begin : g_inner
      assign right_entry = cell_q[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .valid      (valid),
      .left_keep  (left_keep),
      .left_entry (left_entry),
      .right_entry(right_entry),
      .entry      (cell_q[i]),
      .keep       (keep[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (s_accept) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
    if (s_accept) begin
      out_head   <= res_head;
      out_status <= res_status;
      out_fill   <= fill_ext[FILL_W-1:0];
      out_empty  <= (count_next == '0);
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_empty, out_fill, out_head};
  assign m_tuser  = out_status;

  `SPQ_ASSERT(a_count_bound, count <= CW'(DEPTH))
  `SPQ_ASSERT(a_full_drop, s_accept && s_tuser == REQ_ENQ && count == CW'(DEPTH) |=> m_tvalid && m_tuser == ST_FULL && count == $past(count))
  `SPQ_ASSERT(a_count_step, s_accept |=> count == $past(count) || count == $past(count) + 1'b1 || count + 1'b1 == $past(count))
  `SPQ_ASSERT(a_fail_zero, m_tvalid && m_tuser != ST_OK |-> m_tdata[DATA_W-1:0] == '0)
  `SPQ_ASSERT_RST(a_reset, rst |=> count == '0 && !m_tvalid)

endmodule
